### rtl/gaussian_polar_sample_gen_core_assert.svh
// assertion macros for the polar gaussian sample generator
// used by the port checker, needs i_clk and i_rst_n in scope
`ifndef GAUSSIAN_POLAR_SAMPLE_GEN_CORE_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLE_GEN_CORE_ASSERT_SVH

// implication checked on every clock edge out of reset
`define GPSG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define GPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gpsg_pkg.sv
// shared types, constants and helper functions of the polar gaussian generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gpsg_pkg;

    localparam logic [7:0] CFG_AVERAGE = 8'd0;
    localparam logic [7:0] CFG_SIGMA   = 8'd1;

    localparam logic [4:0] DIV_STEPS  = 5'd31;
    localparam logic [4:0] SQRT_STEPS = 5'd18;

    localparam logic [15:0] HALF_RANGE = 16'd16384;
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [5:0]  LOG_FULL   = 6'd20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ1,
        S_SQ2,
        S_LOG,
        S_DINIT,
        S_DIV,
        S_SINIT,
        S_SQRT,
        S_MUL1,
        S_MUL2,
        S_ADJ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic sq1;
        logic sq2;
        logic log_step;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic mul1;
        logic mul2;
        logic adj;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic n_ge100;
        logic out_free;
    } t_status;

    function automatic logic [2:0] log_head(input logic [6:0] n);
        logic [2:0] h;
        if (n < 7'd2)       h = 3'd0;
        else if (n < 7'd7)  h = 3'd1;
        else if (n < 7'd19) h = 3'd2;
        else if (n < 7'd54) h = 3'd3;
        else                h = 3'd4;
        return h;
    endfunction

    // floor(23 * steps / 10)
    function automatic logic [4:0] log_tail(input logic [2:0] steps);
        logic [4:0] t;
        case (steps)
            3'd0: t = 5'd0;
            3'd1: t = 5'd2;
            3'd2: t = 5'd4;
            3'd3: t = 5'd6;
            3'd4: t = 5'd9;
            3'd5: t = 5'd11;
            3'd6: t = 5'd13;
            3'd7: t = 5'd16;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/gaussian_polar_sample_gen_core.sv
// top level of the polar gaussian sample generator
// instantiates gpsg_ctrl and gpsg_datapath, depends on gpsg_pkg
//
// channel   direction  handshake              payload
// s_axis    in         tvalid / tready        rand_first, rand_second
// m_axis    out        tvalid / tready        sample (tdata), accepted (tuser)
// cfg       in         cfg_valid / cfg_ready  register index, write data
//
// one item at a time: an accepted pair runs through the divide-by-ten loop (up to 7 steps),
// the 31-step divider and the 18-step square root before its result is ready
// a rejected pair skips the loop, the divider and the square root
// synchronous active-low reset clears the controller state, the configuration registers and the output valid
// a stalled result holds the last state until taken; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module gaussian_polar_sample_gen_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] rand_first, [31:16] rand_second
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [34:0] sample, [39:35] zero
    output logic [0:0]  m_axis_tuser,   // [0] accepted
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [19:0] i_cfg_data
);

    gpsg_pkg::t_cmd    cmd;
    gpsg_pkg::t_status status;
    logic              accepted;
    logic [34:0]       sample;

    assign o_cfg_ready = 1'b1;

    gpsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gpsg_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_rand_first  (s_axis_tdata[15:0]),
        .i_rand_second (s_axis_tdata[31:16]),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_accepted    (accepted),
        .o_sample      (sample)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {5'd0, sample};
    assign m_axis_tuser  = accepted;

endmodule

`default_nettype wire

### rtl/gpsg_ctrl.sv
// controller state machine sequencing the datapath
// depends on gpsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpsg_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire gpsg_pkg::t_status i_status,
    output gpsg_pkg::t_cmd         o_cmd
);

    gpsg_pkg::t_state r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpsg_pkg::S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            gpsg_pkg::S_IDLE:  if (i_in_valid) n_state = gpsg_pkg::S_SQ1;
            gpsg_pkg::S_SQ1:   n_state = gpsg_pkg::S_SQ2;
            gpsg_pkg::S_SQ2:   n_state = gpsg_pkg::S_LOG;
            gpsg_pkg::S_LOG: begin
                if (i_status.reject)        n_state = gpsg_pkg::S_FIN;
                else if (!i_status.n_ge100) n_state = gpsg_pkg::S_DINIT;
            end
            gpsg_pkg::S_DINIT: begin
                n_state = gpsg_pkg::S_DIV;
                n_cnt   = 5'd0;
            end
            gpsg_pkg::S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gpsg_pkg::DIV_STEPS - 5'd1) n_state = gpsg_pkg::S_SINIT;
            end
            gpsg_pkg::S_SINIT: begin
                n_state = gpsg_pkg::S_SQRT;
                n_cnt   = 5'd0;
            end
            gpsg_pkg::S_SQRT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gpsg_pkg::SQRT_STEPS - 5'd1) n_state = gpsg_pkg::S_MUL1;
            end
            gpsg_pkg::S_MUL1:  n_state = gpsg_pkg::S_MUL2;
            gpsg_pkg::S_MUL2:  n_state = gpsg_pkg::S_ADJ;
            gpsg_pkg::S_ADJ:   n_state = gpsg_pkg::S_FIN;
            gpsg_pkg::S_FIN:   if (i_status.out_free) n_state = gpsg_pkg::S_IDLE;
            default:           n_state = gpsg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            gpsg_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            gpsg_pkg::S_SQ1:   o_cmd.sq1 = 1'b1;
            gpsg_pkg::S_SQ2:   o_cmd.sq2 = 1'b1;
            gpsg_pkg::S_LOG:   o_cmd.log_step = !i_status.reject && i_status.n_ge100;
            gpsg_pkg::S_DINIT: o_cmd.div_init = 1'b1;
            gpsg_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            gpsg_pkg::S_SINIT: o_cmd.sqrt_init = 1'b1;
            gpsg_pkg::S_SQRT:  o_cmd.sqrt_step = 1'b1;
            gpsg_pkg::S_MUL1:  o_cmd.mul1 = 1'b1;
            gpsg_pkg::S_MUL2:  o_cmd.mul2 = 1'b1;
            gpsg_pkg::S_ADJ:   o_cmd.adj = 1'b1;
            gpsg_pkg::S_FIN:   o_cmd.fin = i_status.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/gpsg_datapath.sv
// datapath: squares, divide-by-ten log, restoring divider, square root, scaling
// holds the configuration registers and the output register; depends on gpsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpsg_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire gpsg_pkg::t_cmd i_cmd,
    output gpsg_pkg::t_status   o_status,
    input  wire  [15:0]         i_rand_first,
    input  wire  [15:0]         i_rand_second,
    input  wire                 i_cfg_write,
    input  wire  [7:0]          i_cfg_index,
    input  wire  [19:0]         i_cfg_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_accepted,
    output logic [34:0]         o_sample
);

    logic [19:0]        r_average;
    logic [15:0]        r_sigma;
    logic signed [15:0] r_u1, r_u2;
    logic [29:0]        r_sq;
    logic [29:0]        r_w;
    logic               r_rej;
    logic [29:0]        r_n;
    logic [2:0]         r_steps;
    logic [5:0]         r_coef;
    logic [29:0]        r_rem;
    logic [30:0]        r_q;
    logic [30:0]        r_dvd;
    logic [35:0]        r_x, r_root, r_bit;
    logic signed [32:0] r_p1;
    logic signed [52:0] r_prod;
    logic signed [37:0] r_scaled;
    logic               r_out_valid;
    logic               r_accepted;
    logic [34:0]        r_sample;

    logic signed [31:0] sq1_full, sq2_full;
    logic [63:0]        ten_prod;
    logic [5:0]         log_val;
    logic [30:0]        rem_sh;
    logic [36:0]        x_full;
    logic [35:0]        sqrt_t;
    logic signed [52:0] prod_bias;
    logic [37:0]        sample_sum;

    assign sq1_full   = r_u1 * r_u1;
    assign sq2_full   = r_u2 * r_u2;
    assign ten_prod   = {2'b00, r_n} * gpsg_pkg::RECIP_TEN;
    assign log_val    = {3'b000, gpsg_pkg::log_head(r_n[6:0])}
                      + {1'b0, gpsg_pkg::log_tail(r_steps)};
    assign rem_sh     = {r_rem, r_dvd[30]};
    assign x_full     = {31'd0, r_coef} * {6'd0, r_q};
    assign sqrt_t     = r_root + r_bit;
    assign prod_bias  = r_prod + (r_prod[52] ? 53'sd32767 : 53'sd0);
    assign sample_sum = {18'd0, r_average} + r_scaled;

    assign o_status.reject   = r_rej;
    assign o_status.n_ge100  = (r_n >= 30'd100);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average <= 20'd0;
            r_sigma   <= 16'd0;
        end else if (i_cfg_write) begin
            if (i_cfg_index == gpsg_pkg::CFG_AVERAGE) r_average <= i_cfg_data;
            else if (i_cfg_index == gpsg_pkg::CFG_SIGMA) r_sigma <= i_cfg_data[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u1 <= $signed({1'b0, i_rand_first[14:0]}) - $signed(gpsg_pkg::HALF_RANGE);
            r_u2 <= $signed({1'b0, i_rand_second[14:0]}) - $signed(gpsg_pkg::HALF_RANGE);
        end
        if (i_cmd.sq1) r_sq <= sq1_full[29:0];
        if (i_cmd.sq2) begin
            r_w     <= r_sq + sq2_full[29:0];
            r_n     <= r_sq + sq2_full[29:0];
            r_steps <= 3'd0;
            r_rej   <= ((r_sq + sq2_full[29:0]) == 30'd0) || ((r_sq + sq2_full[29:0]) >= 30'h2000_0000);
        end
        if (i_cmd.log_step) begin
            r_n     <= {1'b0, ten_prod[63:35]};
            r_steps <= r_steps + 3'd1;
        end
        if (i_cmd.div_init) begin
            // twice the distance of the log from its full-scale value
            r_coef <= {gpsg_pkg::LOG_FULL[4:0] - log_val[4:0], 1'b0};
            r_rem  <= 30'd0;
            r_q    <= 31'd0;
            r_dvd  <= 31'h4000_0000;
        end
        if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_w}) begin
                r_rem <= 30'(rem_sh - {1'b0, r_w});
                r_q   <= {r_q[29:0], 1'b1};
            end else begin
                r_rem <= rem_sh[29:0];
                r_q   <= {r_q[29:0], 1'b0};
            end
            r_dvd <= {r_dvd[29:0], 1'b0};
        end
        if (i_cmd.sqrt_init) begin
            r_x    <= x_full[35:0];
            r_root <= 36'd0;
            r_bit  <= 36'h4_0000_0000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_x >= sqrt_t) begin
                r_x    <= r_x - sqrt_t;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mul1) r_p1 <= $signed({1'b0, r_sigma}) * r_u1;
        if (i_cmd.mul2) r_prod <= r_p1 * $signed({1'b0, r_root[18:0]});
        // truncation toward zero of the division by 32768
        if (i_cmd.adj) r_scaled <= prod_bias[52:15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_accepted <= !r_rej;
            r_sample   <= r_rej ? 35'd0 : sample_sum[34:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_sample    = r_sample;

endmodule

`default_nettype wire

### rtl/gpsg_checker.sv
// port-level checker for the polar gaussian sample generator, bound to the top
// depends on gaussian_polar_sample_gen_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_polar_sample_gen_core_assert.svh"

module gpsg_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);

    `GPSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `GPSG_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `GPSG_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 40'd0, "rejected result with nonzero sample")
    `GPSG_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:35] == 5'd0, "padding bits set")
    `GPSG_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind gaussian_polar_sample_gen_core gpsg_checker u_gpsg_checker (.*);

`default_nettype wire
